>>> rtl/fbfl_pkg.sv
// ----------------------------------------------------------------------------
// fbfl_pkg: shared types and constants of the block pool allocator
// Field widths, action and status codes, register indexes and config helpers.
// ----------------------------------------------------------------------------
package fbfl_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int ADDR_W     = 32;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
  localparam int LOG2_W     = 5;
  localparam int LOG2_MIN   = 3;
  localparam int LOG2_MAX   = 16;
  localparam int SPAN_W     = CNT_W + LOG2_MAX;
  localparam int CMP_W      = (ADDR_W > SPAN_W) ? ADDR_W : SPAN_W;

  localparam int PDATA_W    = 32;
  localparam int PADDR_W    = 4;
  localparam int REG_IDX_W  = 2;

  localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(MAX_BLOCKS);

  localparam logic [1:0] ACT_ALLOC    = 2'd0;
  localparam logic [1:0] ACT_FREE     = 2'd1;
  localparam logic [1:0] ACT_CONTAINS = 2'd2;
  localparam logic [1:0] ACT_INIT     = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOG2  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] block_address;
    logic              in_pool;
    logic [CNT_W-1:0]  free_blocks_now;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_address;
    logic [LOG2_W-1:0] block_size_log2;
    logic [CNT_W-1:0]  pool_blocks;
  } cfg_t;

  typedef struct packed {
    logic             pop;
    logic             push;
    logic             init;
    logic [IDX_W-1:0] push_idx;
    logic [CNT_W-1:0] count;
  } stk_cmd_t;

  typedef struct packed {
    logic             pop_ok;
    logic [IDX_W-1:0] pop_idx;
    logic [CNT_W-1:0] free_now;
  } stk_rsp_t;

  function automatic logic [LOG2_W-1:0] eff_log2(input logic [LOG2_W-1:0] v);
    logic [LOG2_W-1:0] r;
    r = v;
    if (v < LOG2_W'(LOG2_MIN)) r = LOG2_W'(LOG2_MIN);
    else if (v > LOG2_W'(LOG2_MAX)) r = LOG2_W'(LOG2_MAX);
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : v;
    return r;
  endfunction

endpackage

>>> rtl/fbfl_ram.sv
// ----------------------------------------------------------------------------
// fbfl_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module fbfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/fbfl_addr.sv
// ----------------------------------------------------------------------------
// fbfl_addr: address arithmetic of the pool
// Tests an address against the pool span, maps it to its block index, and
// forms the byte address of an allocated block.
// ----------------------------------------------------------------------------
module fbfl_addr (
  input  fbfl_pkg::cfg_t                    cfg,
  input  logic [fbfl_pkg::ADDR_W-1:0]       address,
  input  logic [fbfl_pkg::IDX_W-1:0]        pop_idx,
  output logic                              hit,
  output logic [fbfl_pkg::IDX_W-1:0]        blk_idx,
  output logic [fbfl_pkg::ADDR_W-1:0]       blk_addr
);

  logic [fbfl_pkg::LOG2_W-1:0] sh;
  logic [fbfl_pkg::CNT_W-1:0]  cnt;
  logic [fbfl_pkg::SPAN_W-1:0] limit;
  logic [fbfl_pkg::ADDR_W-1:0] off;
  logic [fbfl_pkg::ADDR_W-1:0] off_blk;

  assign sh      = fbfl_pkg::eff_log2(cfg.block_size_log2);
  assign cnt     = fbfl_pkg::eff_count(cfg.pool_blocks);
  assign limit   = fbfl_pkg::SPAN_W'(cnt) << sh;
  assign off     = address - cfg.base_address;
  assign off_blk = off >> sh;
  assign blk_idx = off_blk[fbfl_pkg::IDX_W-1:0];

  // The span is compared unwrapped, so a pool running past the top of the
  // address space simply ends there.
  assign hit = (address != '0) && (address >= cfg.base_address) &&
               (fbfl_pkg::CMP_W'(off) < fbfl_pkg::CMP_W'(limit));

  assign blk_addr = cfg.base_address + (fbfl_pkg::ADDR_W'(pop_idx) << sh);

endmodule

>>> rtl/fbfl_stack.sv
// ----------------------------------------------------------------------------
// fbfl_stack: free-list state of the pool
// Linked stack of freed blocks in RAM plus a mark for never-used blocks.
// The RAM is always read at the next head, so the link is ready next cycle.
// ----------------------------------------------------------------------------
module fbfl_stack (
  input  logic                clk,
  input  logic                rst,
  input  fbfl_pkg::stk_cmd_t  cmd,
  output fbfl_pkg::stk_rsp_t  rsp
);

  logic [fbfl_pkg::CNT_W-1:0] head;
  logic [fbfl_pkg::CNT_W-1:0] head_next;
  logic [fbfl_pkg::CNT_W-1:0] mark;
  logic [fbfl_pkg::CNT_W-1:0] mark_next;
  logic [fbfl_pkg::CNT_W-1:0] free_cnt;
  logic [fbfl_pkg::CNT_W-1:0] free_next;
  logic                       fwd_hit;
  logic [fbfl_pkg::CNT_W-1:0] fwd_data;
  logic [fbfl_pkg::CNT_W-1:0] rdata;
  logic [fbfl_pkg::CNT_W-1:0] link_q;
  logic                       we;
  logic                       pop_ok;
  logic [fbfl_pkg::IDX_W-1:0] pop_idx;

  // A push writes the entry that becomes the head, which is also the entry
  // read in that cycle, so the written link is forwarded to the next cycle.
  assign link_q = fwd_hit ? fwd_data : rdata;

  always_comb begin
    head_next = head;
    mark_next = mark;
    free_next = free_cnt;
    we        = 1'b0;
    pop_ok    = 1'b0;
    pop_idx   = head[fbfl_pkg::IDX_W-1:0];
    if (cmd.init) begin
      head_next = fbfl_pkg::NULL_LINK;
      mark_next = '0;
      free_next = cmd.count;
    end else if (cmd.pop) begin
      if (head != fbfl_pkg::NULL_LINK) begin
        pop_ok    = 1'b1;
        head_next = link_q;
      end else if (mark < cmd.count) begin
        pop_ok    = 1'b1;
        pop_idx   = mark[fbfl_pkg::IDX_W-1:0];
        mark_next = mark + 1'b1;
      end
      if (pop_ok && (free_cnt != '0)) begin
        free_next = free_cnt - 1'b1;
      end
    end else if (cmd.push) begin
      we        = 1'b1;
      head_next = fbfl_pkg::CNT_W'(cmd.push_idx);
      if (free_cnt < fbfl_pkg::CNT_W'(fbfl_pkg::MAX_BLOCKS)) begin
        free_next = free_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= fbfl_pkg::NULL_LINK;
      mark     <= '0;
      free_cnt <= fbfl_pkg::CNT_W'(fbfl_pkg::MAX_BLOCKS);
      fwd_hit  <= 1'b0;
    end else begin
      head     <= head_next;
      mark     <= mark_next;
      free_cnt <= free_next;
      fwd_hit  <= we;
    end
    fwd_data <= head;
  end

  fbfl_ram #(
    .WIDTH (fbfl_pkg::CNT_W),
    .DEPTH (fbfl_pkg::MAX_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (we),
    .waddr (cmd.push_idx),
    .wdata (head),
    .raddr (head_next[fbfl_pkg::IDX_W-1:0]),
    .rdata (rdata)
  );

  assign rsp.pop_ok   = pop_ok;
  assign rsp.pop_idx  = pop_idx;
  assign rsp.free_now = free_next;

endmodule

>>> rtl/fixed_block_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_core: LIFO pool of fixed-size blocks
// A request passes the request register, then the result register; the request
// register stalls the input while it holds a request, so none is taken meanwhile.
// Synchronous reset: pool acts as freshly initialized with 256 blocks of 8 bytes.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  fbfl_pkg::req_t                 req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output fbfl_pkg::rsp_t                 rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fbfl_pkg::PADDR_W-1:0]   paddr,
  input  logic [fbfl_pkg::PDATA_W-1:0]   pwdata,
  output logic [fbfl_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  fbfl_pkg::cfg_t                  cfg;
  fbfl_pkg::req_t                  pend;
  logic                            pend_valid;
  logic                            process;
  fbfl_pkg::rsp_t                  rsp_next;
  fbfl_pkg::stk_cmd_t              scmd;
  fbfl_pkg::stk_rsp_t              srsp;
  logic                            hit;
  logic [fbfl_pkg::IDX_W-1:0]      blk_idx;
  logic [fbfl_pkg::ADDR_W-1:0]     blk_addr;
  logic [fbfl_pkg::REG_IDX_W-1:0]  reg_idx;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[fbfl_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address    <= '0;
      cfg.block_size_log2 <= fbfl_pkg::LOG2_W'(fbfl_pkg::LOG2_MIN);
      cfg.pool_blocks     <= fbfl_pkg::CNT_W'(fbfl_pkg::MAX_BLOCKS);
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        fbfl_pkg::REG_BASE:  cfg.base_address    <= pwdata[fbfl_pkg::ADDR_W-1:0];
        fbfl_pkg::REG_LOG2:  cfg.block_size_log2 <= pwdata[fbfl_pkg::LOG2_W-1:0];
        fbfl_pkg::REG_COUNT: cfg.pool_blocks     <= pwdata[fbfl_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      fbfl_pkg::REG_BASE:  prdata = fbfl_pkg::PDATA_W'(cfg.base_address);
      fbfl_pkg::REG_LOG2:  prdata = fbfl_pkg::PDATA_W'(cfg.block_size_log2);
      fbfl_pkg::REG_COUNT: prdata = fbfl_pkg::PDATA_W'(cfg.pool_blocks);
      default:             prdata = '0;
    endcase
  end

  // Request holding register; the request is worked on once the result
  // register can take its result.
  assign req_stall = pend_valid;
  assign process   = pend_valid && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      pend_valid <= 1'b1;
    end else if (process) begin
      pend_valid <= 1'b0;
    end
    if (req_valid && !req_stall) begin
      pend <= req;
    end
  end

  fbfl_addr u_addr (
    .cfg      (cfg),
    .address  (pend.address),
    .pop_idx  (srsp.pop_idx),
    .hit      (hit),
    .blk_idx  (blk_idx),
    .blk_addr (blk_addr)
  );

  assign scmd.pop      = process && (pend.action == fbfl_pkg::ACT_ALLOC);
  assign scmd.push     = process && (pend.action == fbfl_pkg::ACT_FREE) && hit;
  assign scmd.init     = process && (pend.action == fbfl_pkg::ACT_INIT);
  assign scmd.push_idx = blk_idx;
  assign scmd.count    = fbfl_pkg::eff_count(cfg.pool_blocks);

  fbfl_stack u_stack (
    .clk (clk),
    .rst (rst),
    .cmd (scmd),
    .rsp (srsp)
  );

  always_comb begin
    rsp_next.status          = fbfl_pkg::ST_OK;
    rsp_next.block_address   = '0;
    rsp_next.in_pool         = 1'b0;
    rsp_next.free_blocks_now = srsp.free_now;
    unique case (pend.action)
      fbfl_pkg::ACT_ALLOC: begin
        if (srsp.pop_ok) begin
          rsp_next.block_address = blk_addr;
        end else begin
          rsp_next.status = fbfl_pkg::ST_EMPTY;
        end
      end
      fbfl_pkg::ACT_FREE: begin
        if (!hit) begin
          rsp_next.status = fbfl_pkg::ST_REJECT;
        end
      end
      fbfl_pkg::ACT_CONTAINS: begin
        rsp_next.in_pool = hit;
      end
      fbfl_pkg::ACT_INIT: ;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (process) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (process) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    process |=> rsp_valid)
    else $error("worked request did not produce a result beat");

  a_empty_null: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status == fbfl_pkg::ST_EMPTY)) |-> (rsp.block_address == '0))
    else $error("failed alloc returned a nonzero block address");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.free_blocks_now <= fbfl_pkg::CNT_W'(fbfl_pkg::MAX_BLOCKS)))
    else $error("free block count above pool capacity");

  a_push_in_range: assert property (@(posedge clk) disable iff (rst)
    scmd.push |-> (pend.address != '0))
    else $error("null address pushed onto the free list");
`endif

endmodule
